// ===== hw/rtl/scpr_pkg.sv =====
// ----------------------------------------------------------------------------
// scpr_pkg
// Types, constants and register codes shared by the charge regulator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package scpr_pkg;

   // Divider and reference setup of the battery sense path
   localparam int REF_MILLIVOLTS   = 3300;
   localparam int DIVIDER_NUM      = 2;
   localparam int DIVIDER_DEN      = 1;
   localparam int ADC_FULL_SCALE   = 1023;

   // Field widths
   localparam int ADC_W            = 10;
   localparam int TEMP_W           = 8;
   localparam int MV_W             = 16;
   localparam int DUTY_W           = 8;
   localparam int GAIN_W           = 16;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 16;

   // Control loop constants
   localparam int GAIN_DIV         = 256;
   localparam int GAIN_SHIFT       = $clog2(GAIN_DIV);
   localparam int DUTY_FULL        = 255;
   localparam int COLD_THRESHOLD_C = 5;

   localparam logic [DUTY_W-1:0]        DUTY_FULL_V  = DUTY_W'(DUTY_FULL);
   localparam logic [MV_W-1:0]          MV_MAX_V     = '1;
   localparam logic signed [TEMP_W-1:0] COLD_LIMIT_T = TEMP_W'(COLD_THRESHOLD_C);

   // Millivolt scaling: floor(adc * SCALE_NUM / SCALE_DEN) by a rounded-up reciprocal
   localparam longint unsigned SCALE_NUM   = longint'(REF_MILLIVOLTS) * longint'(DIVIDER_NUM);
   localparam longint unsigned SCALE_DEN   = longint'(DIVIDER_DEN) * longint'(ADC_FULL_SCALE);
   localparam longint unsigned NUM_MAX     = SCALE_NUM * longint'(ADC_FULL_SCALE);
   localparam int              NUM_BITS    = $clog2(NUM_MAX + 1);
   localparam int              DEN_BITS    = $clog2(SCALE_DEN + 1);
   localparam int              SCALE_SHIFT = NUM_BITS + DEN_BITS;
   localparam longint unsigned SCALE_RECIP =
      ((64'd1 << SCALE_SHIFT) + SCALE_DEN - 64'd1) / SCALE_DEN;
   localparam longint unsigned SCALE_MULT  = SCALE_NUM * SCALE_RECIP;
   localparam int              MULT_W      = $clog2(SCALE_MULT + 1);
   localparam int              PROD_W      = ADC_W + MULT_W;

   // Duty update datapath widths
   localparam int ERR_W   = MV_W + 1;
   localparam int STEP_W  = ERR_W + GAIN_W + 1;
   localparam int SUM_W   = STEP_W + 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RESPONSE_GAIN = 2'd0,
      CSR_SAFE_LEVEL    = 2'd1,
      CSR_COLD_MAX_DUTY = 2'd2,
      CSR_TARGET_MV     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_FULL = 2'd1,
      MODE_PWM  = 2'd2
   } drive_mode_type;

   typedef struct packed {
      logic [ADC_W-1:0]         adc_reading;
      logic signed [TEMP_W-1:0] internal_temp;
      logic signed [TEMP_W-1:0] external_temp;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      drive_mode_type    drive_mode;
      logic [MV_W-1:0]   battery_mv;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] response_gain;
      logic [MV_W-1:0]   safe_charge_level_mv;
      logic [DUTY_W-1:0] cold_max_duty;
      logic [MV_W-1:0]   target_voltage_mv;
   } cfg_type;

   typedef struct packed {
      logic [MV_W-1:0]         battery_mv;
      logic signed [ERR_W-1:0] error;
      logic [DUTY_W-1:0]       limit;
   } ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/scpr_front.sv =====
// ----------------------------------------------------------------------------
// scpr_front
// Scale the sense sample to millivolts, take the voltage error and pick the
// duty ceiling from the cold-charge rule and the safe charge level.
// ----------------------------------------------------------------------------
`default_nettype none

module scpr_front (
   input  scpr_pkg::req_type item,
   input  scpr_pkg::cfg_type cfg,
   output scpr_pkg::ctl_type ctl
);

   logic [scpr_pkg::PROD_W-1:0] scaled;
   logic [scpr_pkg::PROD_W-1:0] quotient;
   logic [scpr_pkg::MV_W-1:0]   mv;
   logic                        freezing;

   assign scaled   = scpr_pkg::PROD_W'(item.adc_reading) *
                     scpr_pkg::PROD_W'(scpr_pkg::SCALE_MULT);
   assign quotient = scaled >> scpr_pkg::SCALE_SHIFT;
   assign mv       = (quotient > scpr_pkg::PROD_W'(scpr_pkg::MV_MAX_V)) ?
                     scpr_pkg::MV_MAX_V : quotient[scpr_pkg::MV_W-1:0];

   assign freezing = (item.internal_temp < 0) ||
                     ((item.internal_temp < scpr_pkg::COLD_LIMIT_T) &&
                      (item.external_temp < scpr_pkg::COLD_LIMIT_T));

   always_comb begin
      ctl.battery_mv = mv;
      ctl.error      = $signed({1'b0, cfg.target_voltage_mv}) - $signed({1'b0, mv});
      if (mv < cfg.safe_charge_level_mv) begin
         ctl.limit = scpr_pkg::DUTY_FULL_V;
      end else if (freezing) begin
         ctl.limit = cfg.cold_max_duty;
      end else begin
         ctl.limit = scpr_pkg::DUTY_FULL_V;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/scpr_update.sv =====
// ----------------------------------------------------------------------------
// scpr_update
// Step the stored duty by gain * error / 256 (toward zero), clamp it and
// derive the drive mode.
// ----------------------------------------------------------------------------
`default_nettype none

module scpr_update (
   input  scpr_pkg::ctl_type             ctl,
   input  logic [scpr_pkg::GAIN_W-1:0]   response_gain,
   input  logic [scpr_pkg::DUTY_W-1:0]   current_duty,
   output scpr_pkg::rsp_type             rsp
);

   logic signed [scpr_pkg::STEP_W-1:0] product;
   logic signed [scpr_pkg::STEP_W-1:0] biased;
   logic signed [scpr_pkg::SUM_W-1:0]  change;
   logic signed [scpr_pkg::SUM_W-1:0]  next_duty;
   logic signed [scpr_pkg::SUM_W-1:0]  limit_wide;
   logic [scpr_pkg::DUTY_W-1:0]        duty;

   assign product    = ctl.error * $signed({1'b0, response_gain});
   assign biased     = product[scpr_pkg::STEP_W-1] ?
                       product + scpr_pkg::STEP_W'(scpr_pkg::GAIN_DIV - 1) : product;
   assign change     = scpr_pkg::SUM_W'(biased >>> scpr_pkg::GAIN_SHIFT);
   assign next_duty  = change + $signed(scpr_pkg::SUM_W'({1'b0, current_duty}));
   assign limit_wide = $signed(scpr_pkg::SUM_W'({1'b0, ctl.limit}));

   always_comb begin
      if (next_duty <= 0) begin
         duty = '0;
      end else if (next_duty >= limit_wide) begin
         duty = ctl.limit;
      end else begin
         duty = next_duty[scpr_pkg::DUTY_W-1:0];
      end

      rsp.duty       = duty;
      rsp.battery_mv = ctl.battery_mv;
      if (duty == '0) begin
         rsp.drive_mode = scpr_pkg::MODE_OFF;
      end else if (duty == scpr_pkg::DUTY_FULL_V) begin
         rsp.drive_mode = scpr_pkg::MODE_FULL;
      end else begin
         rsp.drive_mode = scpr_pkg::MODE_PWM;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/solar_charge_pwm_regulator.sv =====
// ----------------------------------------------------------------------------
// solar_charge_pwm_regulator
// PWM charge regulator: battery sample in, new duty, drive mode and battery
// voltage out.
// ----------------------------------------------------------------------------
// Takes one sample per clock unless a stalled result fills the pipe, and
// returns one result per sample, in order. The path is an input register, a
// front stage (millivolt scaling, error, cold ceiling) and a back stage (gain
// multiply, duty step and clamp) that writes the result register and the
// stored duty in the same cycle, so unstalled samples chain through the stored
// duty at one per clock. Empty stages fill while the result waits; a stalled
// result holds the pipe only as far back as it is full. The user must write
// registers via the csr_ port only while no sample is in flight; unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

module solar_charge_pwm_regulator (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  scpr_pkg::req_type                   req_data,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output scpr_pkg::rsp_type                   rsp_data,

   input  logic                                csr_wr_en,
   input  logic [scpr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [scpr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                          in_v_ff,  in_v_in;
   scpr_pkg::req_type             in_ff,    in_in;
   logic                          mid_v_ff, mid_v_in;
   scpr_pkg::ctl_type             mid_ff,   mid_in;
   logic                          out_v_ff, out_v_in;
   scpr_pkg::rsp_type             out_ff,   out_in;
   logic [scpr_pkg::DUTY_W-1:0]   duty_ff,  duty_in;
   scpr_pkg::cfg_type             cfg_ff,   cfg_in;

   scpr_pkg::ctl_type             front_ctl;
   scpr_pkg::rsp_type             back_rsp;

   logic                          out_ready;
   logic                          mid_ready;
   logic                          in_ready;
   logic                          load_in;
   logic                          load_mid;
   logic                          load_out;

   scpr_front u_front (
      .item (in_ff),
      .cfg  (cfg_ff),
      .ctl  (front_ctl)
   );

   scpr_update u_update (
      .ctl           (mid_ff),
      .response_gain (cfg_ff.response_gain),
      .current_duty  (duty_ff),
      .rsp           (back_rsp)
   );

   assign out_ready = !out_v_ff || rsp_ready;
   assign mid_ready = !mid_v_ff || out_ready;
   assign in_ready  = !in_v_ff  || mid_ready;

   assign load_in   = req_valid && in_ready;
   assign load_mid  = in_v_ff   && mid_ready;
   assign load_out  = mid_v_ff  && out_ready;

   assign req_ready = in_ready;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      in_v_in  = in_ready  ? req_valid : in_v_ff;
      mid_v_in = mid_ready ? in_v_ff   : mid_v_ff;
      out_v_in = out_ready ? mid_v_ff  : out_v_ff;

      in_in    = load_in  ? req_data  : in_ff;
      mid_in   = load_mid ? front_ctl : mid_ff;
      out_in   = load_out ? back_rsp  : out_ff;
      duty_in  = load_out ? back_rsp.duty : duty_ff;

      cfg_in   = cfg_ff;
      if (csr_wr_en) begin
         case (scpr_pkg::csr_index_type'(csr_index))
            scpr_pkg::CSR_RESPONSE_GAIN: begin
               cfg_in.response_gain = csr_wdata[scpr_pkg::GAIN_W-1:0];
            end
            scpr_pkg::CSR_SAFE_LEVEL: begin
               cfg_in.safe_charge_level_mv = csr_wdata[scpr_pkg::MV_W-1:0];
            end
            scpr_pkg::CSR_COLD_MAX_DUTY: begin
               cfg_in.cold_max_duty = csr_wdata[scpr_pkg::DUTY_W-1:0];
            end
            scpr_pkg::CSR_TARGET_MV: begin
               cfg_in.target_voltage_mv = csr_wdata[scpr_pkg::MV_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         mid_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         duty_ff  <= '0;
         cfg_ff   <= '0;
      end else begin
         in_v_ff  <= in_v_in;
         mid_v_ff <= mid_v_in;
         out_v_ff <= out_v_in;
         duty_ff  <= duty_in;
         cfg_ff   <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      mid_ff <= mid_in;
      out_ff <= out_in;
   end

   a_duty_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.duty == duty_ff))
      else $error("result duty differs from stored duty");

   a_mode_coding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_data.duty == '0) == (rsp_data.drive_mode == scpr_pkg::MODE_OFF)) &&
                     ((rsp_data.duty == scpr_pkg::DUTY_FULL_V) ==
                      (rsp_data.drive_mode == scpr_pkg::MODE_FULL))))
      else $error("drive mode does not match duty");

   a_duty_hold: assert property (@(posedge clock) disable iff (reset)
      !load_out |=> $stable(duty_ff))
      else $error("stored duty changed without a result load");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      load_in |=> in_v_ff)
      else $error("transfer did not fill the input register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (mid_v_ff && !out_ready) |=> (mid_v_ff && $stable(mid_ff)))
      else $error("stalled back stage lost its item");

endmodule

`default_nettype wire
